>>> rtl/core/checksum_frame_receiver_top_assert.svh
// Assertion macros for the checksum frame receiver.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef CHECKSUM_FRAME_RECEIVER_TOP_ASSERT_SVH
`define CHECKSUM_FRAME_RECEIVER_TOP_ASSERT_SVH

// Property checked at every rising clock edge outside reset.
`define CFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define CFR_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/core/cfr_pkg.sv
// Shared types and constants of the checksum frame receiver.
// No dependencies.
`timescale 1ns / 1ps

package cfr_pkg;

  localparam logic [15:0] SYNC_RESET = 16'hFDFD;
  localparam int unsigned MIN_FRAME  = 10;
  localparam int unsigned HEAD_BYTES = 8;
  localparam int unsigned COUNT_MAX  = 511;

  // byte positions of the header fields
  localparam logic [8:0] POS_SYNC_HI = 9'd0;
  localparam logic [8:0] POS_SYNC_LO = 9'd1;
  localparam logic [8:0] POS_TOTAL   = 9'd3;
  localparam logic [8:0] POS_CMD_HI  = 9'd5;
  localparam logic [8:0] POS_CMD_LO  = 9'd6;
  localparam logic [8:0] POS_LEN     = 9'd7;

  // configuration register index (taken from paddr[2])
  localparam logic REG_SYNC_WORD = 1'b0;

  typedef enum logic [2:0] {
    VERD_GOOD     = 3'd0,
    VERD_SHORT    = 3'd1,
    VERD_BAD_SYNC = 3'd2,
    VERD_LEN_ERR  = 3'd3,
    VERD_CSUM_ERR = 3'd4
  } verdict_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [15:0] frame_command;
    verdict_t    verdict;
    logic        last_of_run;
  } result_t;

endpackage

>>> rtl/core/cfr_in_if.sv
// Input byte channel of the checksum frame receiver.
// Standalone; valid/ready handshake.
`timescale 1ns / 1ps

interface cfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       chunk_end;

  modport source (output valid, rx_byte, chunk_end, input ready);
  modport sink   (input valid, rx_byte, chunk_end, output ready);
endinterface

>>> rtl/core/cfr_out_if.sv
// Result channel of the checksum frame receiver.
// Standalone; valid/ready handshake.
`timescale 1ns / 1ps

interface cfr_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  payload_byte;
  logic [15:0] frame_command;
  logic [2:0]  verdict;
  logic        last_of_run;

  modport source (output valid, result_kind, payload_byte, frame_command, verdict,
                  last_of_run, input ready);
  modport sink   (input valid, result_kind, payload_byte, frame_command, verdict,
                  last_of_run, output ready);
endinterface

>>> rtl/core/checksum_frame_receiver_top.sv
// Checksum frame receiver: parses sync/length/checksum frames from a byte stream.
// Depends on cfr_pkg, cfr_in_if, cfr_out_if and checksum_frame_receiver_top_assert.svh.
// One byte is taken per clock cycle while input ready is high. Its results (a payload
// byte, a frame verdict, or both on a chunk-end payload byte) are computed in the accept
// cycle and written to a four-entry result queue, which passes them out in order.
// Input ready is high while the queue holds two entries or fewer, so the stream runs at
// one byte per cycle as long as the output drains one result per cycle; only bytes that
// give two results can build up the queue. Reset is synchronous; no clearing pass.
`timescale 1ns / 1ps
`include "checksum_frame_receiver_top_assert.svh"

module checksum_frame_receiver_top (
  input  logic        clk,
  input  logic        rst_n,
  cfr_in_if.sink      in_ch,
  cfr_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // configuration
  logic [15:0] sync_r;

  // frame state
  logic [8:0]  byte_count_r, byte_count_nxt;
  logic [15:0] header_r, header_nxt;
  logic [7:0]  total_r, total_nxt;
  logic [15:0] command_r, command_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [15:0] check_r, check_nxt;

  // result queue
  cfr_pkg::result_t q_r [4];
  logic [1:0] wr_ptr_r;
  logic [1:0] rd_ptr_r;
  logic [2:0] q_cnt_r;

  logic       in_acc;
  logic       out_acc;
  logic       is_payload;
  logic [1:0] push_n;
  cfr_pkg::result_t res0, res1;
  cfr_pkg::verdict_t verd;

  assign in_acc       = in_ch.valid & in_ch.ready;
  assign out_acc      = out_ch.valid & out_ch.ready;
  assign in_ch.ready  = (q_cnt_r <= 3'd2);

  // ---------------------------------------------------------------- parsing
  always_comb begin
    logic [7:0] b;
    logic [8:0] p;
    logic [8:0] data_end;
    logic       in_data;
    logic [9:0] need;
    b = in_ch.rx_byte;
    p = byte_count_r;
    header_nxt  = header_r;
    total_nxt   = total_r;
    command_nxt = command_r;
    len_nxt     = len_r;
    check_nxt   = check_r;
    case (p)
      cfr_pkg::POS_SYNC_HI: header_nxt[15:8]  = b;
      cfr_pkg::POS_SYNC_LO: header_nxt[7:0]   = b;
      cfr_pkg::POS_TOTAL:   total_nxt         = b;
      cfr_pkg::POS_CMD_HI:  command_nxt[15:8] = b;
      cfr_pkg::POS_CMD_LO:  command_nxt[7:0]  = b;
      cfr_pkg::POS_LEN:     len_nxt           = b;
      default: ;
    endcase
    data_end   = 9'(cfr_pkg::HEAD_BYTES) + {1'b0, len_nxt};
    in_data    = (p < data_end);
    sum_nxt    = in_data ? (sum_r + {8'd0, b}) : sum_r;
    is_payload = (p >= 9'(cfr_pkg::HEAD_BYTES)) && in_data;
    // check bytes follow the payload
    if (p >= 9'(cfr_pkg::HEAD_BYTES) && p == data_end) begin
      check_nxt[15:8] = b;
    end
    if (p >= 9'(cfr_pkg::HEAD_BYTES) && {1'b0, p} == {1'b0, data_end} + 10'd1) begin
      check_nxt[7:0] = b;
    end
    byte_count_nxt = (p < 9'(cfr_pkg::COUNT_MAX)) ? p + 9'd1 : p;

    need = 10'(cfr_pkg::MIN_FRAME) + {2'b00, len_nxt};
    if (byte_count_nxt < 9'(cfr_pkg::MIN_FRAME)) begin
      verd = cfr_pkg::VERD_SHORT;
    end else if (header_nxt != sync_r) begin
      verd = cfr_pkg::VERD_BAD_SYNC;
    end else if (byte_count_nxt != {1'b0, total_nxt}) begin
      verd = cfr_pkg::VERD_LEN_ERR;
    end else if (need > {1'b0, byte_count_nxt}) begin
      verd = cfr_pkg::VERD_LEN_ERR;
    end else if (sum_nxt != check_nxt) begin
      verd = cfr_pkg::VERD_CSUM_ERR;
    end else begin
      verd = cfr_pkg::VERD_GOOD;
    end
  end

  // results of the current byte, in emission order
  always_comb begin
    cfr_pkg::result_t pay, fin;
    pay.kind          = cfr_pkg::KIND_PAYLOAD;
    pay.payload_byte  = in_ch.rx_byte;
    pay.frame_command = 16'd0;
    pay.verdict       = cfr_pkg::VERD_GOOD;
    pay.last_of_run   = ~in_ch.chunk_end;
    fin.kind          = cfr_pkg::KIND_VERDICT;
    fin.payload_byte  = 8'd0;
    fin.frame_command = command_nxt;
    fin.verdict       = verd;
    fin.last_of_run   = 1'b1;
    res0   = is_payload ? pay : fin;
    res1   = fin;
    push_n = {1'b0, is_payload} + {1'b0, in_ch.chunk_end};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      header_r     <= '0;
      total_r      <= '0;
      command_r    <= '0;
      len_r        <= '0;
      sum_r        <= '0;
      check_r      <= '0;
    end else if (in_acc) begin
      if (in_ch.chunk_end) begin
        byte_count_r <= '0;
        header_r     <= '0;
        total_r      <= '0;
        command_r    <= '0;
        len_r        <= '0;
        sum_r        <= '0;
        check_r      <= '0;
      end else begin
        byte_count_r <= byte_count_nxt;
        header_r     <= header_nxt;
        total_r      <= total_nxt;
        command_r    <= command_nxt;
        len_r        <= len_nxt;
        sum_r        <= sum_nxt;
        check_r      <= check_nxt;
      end
    end
  end

  // ---------------------------------------------------------------- result queue
  always_ff @(posedge clk) begin
    if (in_acc && push_n != 2'd0) begin
      q_r[wr_ptr_r] <= res0;
    end
    if (in_acc && push_n == 2'd2) begin
      q_r[wr_ptr_r + 2'd1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      if (in_acc) begin
        wr_ptr_r <= wr_ptr_r + push_n;
      end
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
      q_cnt_r <= q_cnt_r + (in_acc ? {1'b0, push_n} : 3'd0) - {2'b00, out_acc};
    end
  end

  assign out_ch.valid         = (q_cnt_r != 3'd0);
  assign out_ch.result_kind   = q_r[rd_ptr_r].kind;
  assign out_ch.payload_byte  = q_r[rd_ptr_r].payload_byte;
  assign out_ch.frame_command = q_r[rd_ptr_r].frame_command;
  assign out_ch.verdict       = q_r[rd_ptr_r].verdict;
  assign out_ch.last_of_run   = q_r[rd_ptr_r].last_of_run;

  // ---------------------------------------------------------------- config port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= cfr_pkg::SYNC_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == cfr_pkg::REG_SYNC_WORD) begin
      sync_r <= cfg_pwdata[15:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == cfr_pkg::REG_SYNC_WORD) ? {16'd0, sync_r} : 32'd0;

  // ---------------------------------------------------------------- checks
  `CFR_NEVER(a_queue_overflow, q_cnt_r > 3'd4, "result queue overflow")
  `CFR_ASSERT(a_end_clears, (in_acc && in_ch.chunk_end) |=> (byte_count_r == 9'd0 && sum_r == 16'd0), "chunk end did not clear frame state")
  `CFR_ASSERT(a_verdict_last, (out_ch.valid && out_ch.result_kind == cfr_pkg::KIND_VERDICT) |-> (out_ch.last_of_run && out_ch.payload_byte == 8'd0), "verdict result malformed")
  `CFR_ASSERT(a_verdict_range, out_ch.valid |-> (out_ch.verdict == cfr_pkg::VERD_GOOD || out_ch.verdict == cfr_pkg::VERD_SHORT || out_ch.verdict == cfr_pkg::VERD_BAD_SYNC || out_ch.verdict == cfr_pkg::VERD_LEN_ERR || out_ch.verdict == cfr_pkg::VERD_CSUM_ERR), "verdict code out of range")

endmodule

>>> sim/tb.sv
// Testbench for checksum_frame_receiver_top: random and directed byte chunks, results
// checked in order against a behavioral frame parser. Depends on cfr_pkg, cfr_in_if,
// cfr_out_if and the RTL top.
`timescale 1ns / 1ps

module tb;

  typedef logic [7:0] bytes_t[$];

  localparam logic [2:0]  SYNC_ADDR   = {cfr_pkg::REG_SYNC_WORD, 2'b00};
  localparam int unsigned CYCLE_LIMIT = 300000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  cfr_in_if  in_ch();
  cfr_out_if out_ch();

  checksum_frame_receiver_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parser state, mirrors the block
  logic [15:0] sync_word_m = cfr_pkg::SYNC_RESET;
  logic [8:0]  count_m     = '0;
  logic [15:0] header_m    = '0;
  logic [7:0]  total_m     = '0;
  logic [15:0] command_m   = '0;
  logic [7:0]  plen_m      = '0;
  logic [15:0] sum_m       = '0;
  logic [15:0] check_m     = '0;

  cfr_pkg::result_t frame_results_due[$];
  int unsigned mismatch_count = 0;
  int unsigned bytes_sent     = 0;
  int unsigned cycle_count    = 0;
  int unsigned in_gap_pct     = 0;
  int unsigned out_stall_pct  = 0;

  function automatic void parse_rx_byte(input logic [7:0] value, input logic last);
    int unsigned       data_end;
    int unsigned       frame_len;
    cfr_pkg::verdict_t outcome;
    cfr_pkg::result_t  res;
    data_end = cfr_pkg::HEAD_BYTES + 32'(plen_m);
    case (count_m)
      cfr_pkg::POS_SYNC_HI: header_m[15:8] = value;
      cfr_pkg::POS_SYNC_LO: header_m[7:0] = value;
      cfr_pkg::POS_TOTAL:   total_m = value;
      cfr_pkg::POS_CMD_HI:  command_m[15:8] = value;
      cfr_pkg::POS_CMD_LO:  command_m[7:0] = value;
      cfr_pkg::POS_LEN: begin
        plen_m   = value;
        data_end = cfr_pkg::HEAD_BYTES + 32'(value);
      end
      default: ;
    endcase
    if (32'(count_m) < data_end) sum_m = sum_m + 16'(value);
    if (32'(count_m) >= cfr_pkg::HEAD_BYTES && 32'(count_m) == data_end)
      check_m[15:8] = value;
    if (32'(count_m) >= cfr_pkg::HEAD_BYTES && 32'(count_m) == data_end + 1)
      check_m[7:0] = value;
    if (32'(count_m) >= cfr_pkg::HEAD_BYTES && 32'(count_m) < data_end) begin
      res = '{kind: cfr_pkg::KIND_PAYLOAD, payload_byte: value, frame_command: 16'h0000,
              verdict: cfr_pkg::VERD_GOOD, last_of_run: !last};
      frame_results_due.push_back(res);
    end
    if (32'(count_m) < cfr_pkg::COUNT_MAX) count_m = count_m + 9'd1;

    if (last) begin
      frame_len = 32'(count_m);
      if (frame_len < cfr_pkg::MIN_FRAME) outcome = cfr_pkg::VERD_SHORT;
      else if (header_m != sync_word_m) outcome = cfr_pkg::VERD_BAD_SYNC;
      else if (frame_len != 32'(total_m)) outcome = cfr_pkg::VERD_LEN_ERR;
      else if (cfr_pkg::MIN_FRAME + 32'(plen_m) > frame_len)
        outcome = cfr_pkg::VERD_LEN_ERR;  // payload overruns
      else if (sum_m != check_m) outcome = cfr_pkg::VERD_CSUM_ERR;
      else outcome = cfr_pkg::VERD_GOOD;
      res = '{kind: cfr_pkg::KIND_VERDICT, payload_byte: 8'h00, frame_command: command_m,
              verdict: outcome, last_of_run: 1'b1};
      frame_results_due.push_back(res);
      count_m   = '0;
      header_m  = '0;
      total_m   = '0;
      command_m = '0;
      plen_m    = '0;
      sum_m     = '0;
      check_m   = '0;
    end
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    cfr_pkg::result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (frame_results_due.size() == 0) begin
        $error("unexpected result transaction: kind %0d byte %0h cmd %0h verdict %0d",
               out_ch.result_kind, out_ch.payload_byte, out_ch.frame_command,
               out_ch.verdict);
        mismatch_count++;
      end else begin
        want = frame_results_due.pop_front();
        check_field("result_kind", 16'(want.kind), 16'(out_ch.result_kind));
        check_field("payload_byte", 16'(want.payload_byte), 16'(out_ch.payload_byte));
        check_field("frame_command", want.frame_command, out_ch.frame_command);
        check_field("verdict", 16'(want.verdict), 16'(out_ch.verdict));
        check_field("last_of_run", 16'(want.last_of_run), 16'(out_ch.last_of_run));
      end
    end
  end

  always @(negedge clk) out_ch.ready = ($urandom_range(99) >= out_stall_pct);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --- drivers, entered and left at a falling edge ---

  task automatic send_byte(input logic [7:0] value, input logic last);
    while ($urandom_range(99) < in_gap_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.rx_byte   = value;
    in_ch.chunk_end = last;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    parse_rx_byte(value, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_chunk(input bytes_t q);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  // wait for every result, plus slack for a trailing byte with no result
  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (frame_results_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic check_sync_readback();
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = SYNC_ADDR;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (cfg_pready !== 1'b1) @(posedge clk);
    check_field("sync_word", sync_word_m, cfg_prdata[15:0]);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic write_sync_word(input logic [15:0] value);
    drain_results();
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = SYNC_ADDR;
    cfg_pwdata  = {16'h0000, value};
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (cfg_pready !== 1'b1) @(posedge clk);
    sync_word_m = value;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    check_sync_readback();
  endtask

  // Well-formed frame; extra adds trailing bytes, total_skew corrupts the total-length byte.
  function automatic bytes_t make_frame(input logic [15:0] sync, input logic [7:0] plen,
                                        input int unsigned extra,
                                        input logic [7:0] total_skew, input bit bad_sum);
    bytes_t      q;
    logic [15:0] sum;
    q.push_back(sync[15:8]);
    q.push_back(sync[7:0]);
    q.push_back(8'($urandom));
    q.push_back(8'(cfr_pkg::HEAD_BYTES + 2 + plen + extra) + total_skew);
    q.push_back(8'($urandom));
    q.push_back(8'($urandom));
    q.push_back(8'($urandom));
    q.push_back(plen);
    repeat (plen) q.push_back(8'($urandom));
    sum = '0;
    foreach (q[i]) sum = sum + 16'(q[i]);
    if (bad_sum) sum = sum ^ (16'd1 << $urandom_range(15));
    q.push_back(sum[15:8]);
    q.push_back(sum[7:0]);
    repeat (extra) q.push_back(8'($urandom));
    return q;
  endfunction

  // --- tests ---

  task automatic test_too_short();
    bytes_t q;
    send_byte(8'hFF, 1'b1);
    q = make_frame(sync_word_m, 8'h00, 0, 8'h00, 1'b0);
    while (q.size() > 6) void'(q.pop_back());  // only the high command byte arrives
    send_chunk(q);
  endtask

  task automatic test_good_frame();
    bytes_t q;
    q = make_frame(sync_word_m, 8'h01, 0, 8'h00, 1'b0);
    q[8] = 8'h00;
    // fix up the check after forcing the payload byte
    q[9]  = 8'h00;
    q[10] = 8'h00;
    for (int i = 0; i < 9; i++) {q[9], q[10]} = {q[9], q[10]} + 16'(q[i]);
    send_chunk(q);
  endtask

  task automatic test_payload_overrun();
    bytes_t q;
    q = make_frame(sync_word_m, 8'h02, 0, 8'h00, 1'b0);
    void'(q.pop_back());
    void'(q.pop_back());
    q[3] = 8'(q.size());  // length matches, but the check never arrives
    send_chunk(q);
  endtask

  task automatic test_random_frames(input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned pick;
    logic [7:0]  plen;
    bytes_t      q;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      case ($urandom_range(49))
        0:             plen = 8'($urandom_range(200, 240));
        1, 2, 3, 4, 5: plen = 8'($urandom_range(13, 60));
        default:       plen = 8'($urandom_range(0, 12));
      endcase
      pick = $urandom_range(99);
      if (pick < 45) begin
        q = make_frame(sync_word_m, plen, 0, 8'h00, 1'b0);
      end else if (pick < 60) begin
        q = make_frame(sync_word_m, plen, 0, 8'h00, 1'b1);
      end else if (pick < 68) begin
        q = make_frame(sync_word_m ^ 16'($urandom_range(1, 65535)), plen, 0, 8'h00, 1'b0);
      end else if (pick < 76) begin
        q = make_frame(sync_word_m, plen, 0, 8'($urandom_range(1, 255)), 1'b0);
      end else if (pick < 84) begin
        q = make_frame(sync_word_m, plen, $urandom_range(1, 5), 8'h00, 1'b0);
      end else if (pick < 88) begin
        q = make_frame(sync_word_m, (plen < 2) ? 8'd2 : plen, 0, 8'h00, 1'b0);
        void'(q.pop_back());
        void'(q.pop_back());
        q[3] = 8'(q.size());
      end else if (pick < 95) begin
        q = make_frame(sync_word_m, plen, 0, 8'h00, 1'b0);
        pick = $urandom_range(1, 9);
        while (q.size() > pick) void'(q.pop_back());
      end else begin
        q = {};
        repeat ($urandom_range(1, 30)) q.push_back(8'($urandom));
      end
      send_chunk(q);
    end
  endtask

  // chunk past the counter's saturation point, then a clean frame
  task automatic test_long_chunk();
    send_chunk(make_frame(sync_word_m, 8'($urandom_range(0, 20)), 505, 8'h00, 1'b0));
    send_chunk(make_frame(sync_word_m, 8'($urandom_range(0, 12)), 0, 8'h00, 1'b0));
  endtask

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.rx_byte   = 8'h00;
    in_ch.chunk_end = 1'b0;
    out_ch.ready    = 1'b0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    check_sync_readback();
    in_gap_pct    = 29;
    out_stall_pct = 52;
    test_too_short();
    test_good_frame();
    test_payload_overrun();
    test_random_frames(150);

    write_sync_word(16'hFFFF);
    in_gap_pct    = 52;
    out_stall_pct = 29;
    test_random_frames(150);

    write_sync_word(16'h0000);
    in_gap_pct    = 0;
    out_stall_pct = 0;
    test_random_frames(150);

    write_sync_word(16'($urandom));
    test_long_chunk();

    drain_results();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> checksum_frame_receiver_top.f
+incdir+rtl/core
rtl/core/cfr_pkg.sv
rtl/core/cfr_in_if.sv
rtl/core/cfr_out_if.sv
rtl/core/checksum_frame_receiver_top.sv
sim/tb.sv
